[sv/rtts_pkg.sv]
// Shared types for the ready and timer task scheduler: request and result
// payloads, command and status codes, and the timer cell control group.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtts_pkg;

    localparam int TASK_BITS = 16;

    typedef enum logic [1:0] {
        CMD_PUSH_ONE   = 2'd0,
        CMD_PUSH_TWO   = 2'd1,
        CMD_PUSH_TIMED = 2'd2,
        CMD_DISPATCH   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_NO_TASK    = 3'd2,
        ST_READY_FULL = 3'd3,
        ST_TIMER_FULL = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd                 cmd;
        logic [TASK_BITS-1:0] task_first;
        logic [TASK_BITS-1:0] task_second;
        logic [31:0]          delay_ticks;
        logic [47:0]          time_now;
    } t_request;

    typedef struct packed {
        t_status              status;
        logic [TASK_BITS-1:0] task_out;
        logic [47:0]          waited_ticks;
    } t_result;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     occupied;
        logic     at_tail;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[sv/rtts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rtts_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/rtts_cell.sv]
// One cell of the deadline-sorted timer chain: holds one {deadline, task}
// entry and shifts with its neighbors on insert or pop. Uses rtts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtts_cell #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                 i_clk,
    input  wire rtts_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [TIME_BITS-1:0] i_new_dl,
    input  wire logic [15:0]          i_new_task,
    input  wire logic [TIME_BITS-1:0] i_left_dl,
    input  wire logic [15:0]          i_left_task,
    input  wire logic                 i_left_greater,
    input  wire logic [TIME_BITS-1:0] i_right_dl,
    input  wire logic [15:0]          i_right_task,
    output logic      [TIME_BITS-1:0] o_dl,
    output logic      [15:0]          o_task,
    output logic                      o_greater
);

    import rtts_pkg::*;

    logic [TIME_BITS-1:0] r_dl;
    logic [TIME_BITS-1:0] n_dl;
    logic [15:0]          r_task;
    logic [15:0]          n_task;

    assign o_greater = i_ctrl.occupied && (r_dl > i_new_dl);

    always_comb begin
        n_dl   = r_dl;
        n_task = r_task;
        unique case (i_ctrl.op)
            CELL_INSERT: begin
                if (i_left_greater) begin
                    n_dl   = i_left_dl;
                    n_task = i_left_task;
                end else if (o_greater || i_ctrl.at_tail) begin
                    n_dl   = i_new_dl;
                    n_task = i_new_task;
                end
            end
            CELL_POP: begin
                n_dl   = i_right_dl;
                n_task = i_right_task;
            end
            default: begin
                n_dl   = r_dl;
                n_task = r_task;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_dl   <= n_dl;
        r_task <= n_task;
    end

    assign o_dl   = r_dl;
    assign o_task = r_task;

endmodule

`default_nettype wire

[sv/ready_and_timer_task_scheduler_top.sv]
// Ready and timer task scheduler: FIFO ready queue in RAM plus a sorted
// chain of timer cells. Uses rtts_pkg, rtts_ram and rtts_cell.
//
// One request is taken at a time. Push one, push timed, a dispatch that
// takes its task straight from the timer queue, and any rejected request
// finish in S_EXEC, where their result is registered; push two (the ready RAM
// has one write port) and a dispatch from the ready queue (the RAM read is
// registered) pass through S_SECOND or S_READ after S_EXEC before their result
// is registered. A result waits in the output register while the next request
// is accepted; a second finished result waits until it drains.
`timescale 1ns / 1ps
`default_nettype none

module ready_and_timer_task_scheduler_top #(
    parameter int READY_DEPTH = 16,
    parameter int TIMER_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire rtts_pkg::t_request i_req,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output rtts_pkg::t_result       o_res
);

    import rtts_pkg::*;

    localparam int RAW = $clog2(READY_DEPTH);
    localparam int RCW = $clog2(READY_DEPTH + 1);
    localparam int TCW = $clog2(TIMER_DEPTH + 1);
    localparam int SW  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SECOND,
        S_READ,
        S_HOLD
    } t_state;

    t_state               r_state, n_state;
    t_request             r_req, n_req;
    logic [TIME_BITS-1:0] r_deadline, n_deadline;
    logic [TIME_BITS-1:0] r_cur, n_cur;
    logic [RAW-1:0]       r_head, n_head;
    logic [RCW-1:0]       r_rcount, n_rcount;
    logic [TCW-1:0]       r_tcount, n_tcount;
    t_result              r_res, n_res;
    t_result              r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic [SW-1:0]        w_sum;
    logic [TIME_BITS-1:0] w_dl_in;
    logic [RAW:0]         w_tail_sum;
    logic [RAW-1:0]       w_tail;
    logic [RAW-1:0]       w_head_inc;
    logic                 w_ready_full1;
    logic                 w_ready_full2;
    logic                 w_ready_empty;
    logic                 w_timer_full;
    logic                 w_have_timer;
    logic                 w_out_free;
    logic                 w_fin;
    t_result              w_res;
    t_cell_op             w_cell_op;
    logic                 w_wr_en;
    logic [15:0]          w_wr_data;
    logic                 w_rd_en;
    logic [15:0]          w_rd_data;

    logic [TIME_BITS-1:0] w_dl      [TIMER_DEPTH];
    logic [15:0]          w_task    [TIMER_DEPTH];
    logic                 w_greater [TIMER_DEPTH];

    assign w_sum   = SW'(i_req.time_now[TIME_BITS-1:0]) + SW'(i_req.delay_ticks);
    assign w_dl_in = (w_sum > SW'(TIME_MAX)) ? TIME_MAX : w_sum[TIME_BITS-1:0];

    assign w_tail_sum = (RAW+1)'(r_head) + (RAW+1)'(r_rcount);
    assign w_tail     = (w_tail_sum >= (RAW+1)'(READY_DEPTH))
                        ? RAW'(w_tail_sum - (RAW+1)'(READY_DEPTH))
                        : w_tail_sum[RAW-1:0];
    assign w_head_inc = (r_head == RAW'(READY_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign w_ready_full1 = r_rcount >= RCW'(READY_DEPTH);
    assign w_ready_full2 = ((RCW+1)'(r_rcount) + (RCW+1)'(2)) > (RCW+1)'(READY_DEPTH);
    assign w_ready_empty = r_rcount == '0;
    assign w_timer_full  = r_tcount >= TCW'(TIMER_DEPTH);
    assign w_have_timer  = r_tcount != '0;
    assign w_out_free    = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_deadline  = r_deadline;
        n_cur       = r_cur;
        n_head      = r_head;
        n_rcount    = r_rcount;
        n_tcount    = r_tcount;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        w_cell_op   = CELL_HOLD;
        w_wr_en     = 1'b0;
        w_wr_data   = r_req.task_first;
        w_rd_en     = 1'b0;
        w_fin       = 1'b0;
        w_res.status       = ST_ACCEPTED;
        w_res.task_out     = '0;
        w_res.waited_ticks = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req      = i_req;
                    n_deadline = w_dl_in;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_req.cmd)
                    CMD_PUSH_ONE: begin
                        w_fin = 1'b1;
                        if (w_ready_full1) begin
                            w_res.status = ST_READY_FULL;
                        end else begin
                            w_wr_en  = 1'b1;
                            n_rcount = r_rcount + 1'b1;
                        end
                    end
                    CMD_PUSH_TWO: begin
                        if (w_ready_full2) begin
                            w_fin        = 1'b1;
                            w_res.status = ST_READY_FULL;
                        end else begin
                            w_wr_en  = 1'b1;
                            n_rcount = r_rcount + 1'b1;
                            n_state  = S_SECOND;
                        end
                    end
                    CMD_PUSH_TIMED: begin
                        w_fin = 1'b1;
                        if (w_timer_full) begin
                            w_res.status = ST_TIMER_FULL;
                        end else begin
                            w_cell_op = CELL_INSERT;
                            n_tcount  = r_tcount + 1'b1;
                            n_cur     = r_req.time_now[TIME_BITS-1:0];
                        end
                    end
                    CMD_DISPATCH: begin
                        if (w_have_timer && w_ready_empty) begin
                            w_cell_op      = CELL_POP;
                            n_tcount       = r_tcount - 1'b1;
                            w_fin          = 1'b1;
                            w_res.status   = ST_DISPATCHED;
                            w_res.task_out = w_task[0];
                            if (r_cur < w_dl[0]) begin
                                w_res.waited_ticks = 48'(w_dl[0] - r_cur);
                                n_cur              = w_dl[0];
                            end
                        end else if (!w_ready_empty) begin
                            w_rd_en = 1'b1;
                            n_head  = w_head_inc;
                            n_state = S_READ;
                            if (w_have_timer && (r_cur >= w_dl[0]) && !w_ready_full1) begin
                                w_cell_op = CELL_POP;
                                n_tcount  = r_tcount - 1'b1;
                                w_wr_en   = 1'b1;
                                w_wr_data = w_task[0];
                            end else begin
                                n_rcount = r_rcount - 1'b1;
                            end
                        end else begin
                            w_fin        = 1'b1;
                            w_res.status = ST_NO_TASK;
                        end
                    end
                    default: begin
                        w_fin = 1'b1;
                    end
                endcase
            end
            S_SECOND: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_req.task_second;
                n_rcount  = r_rcount + 1'b1;
                w_fin     = 1'b1;
            end
            S_READ: begin
                w_fin          = 1'b1;
                w_res.status   = ST_DISPATCHED;
                w_res.task_out = w_rd_data;
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            if (w_out_free) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_res   = w_res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_head      <= '0;
            r_rcount    <= '0;
            r_tcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_head      <= n_head;
            r_rcount    <= n_rcount;
            r_tcount    <= n_tcount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_deadline <= n_deadline;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    rtts_ram #(
        .WIDTH(16),
        .DEPTH(READY_DEPTH)
    ) u_ready_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_tail),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(r_head),
        .o_rd_data(w_rd_data)
    );

    for (genvar gi = 0; gi < TIMER_DEPTH; gi++) begin : g_cell
        t_cell_ctrl           w_ctrl;
        logic [TIME_BITS-1:0] w_left_dl;
        logic [15:0]          w_left_task;
        logic                 w_left_greater;
        logic [TIME_BITS-1:0] w_right_dl;
        logic [15:0]          w_right_task;

        assign w_ctrl.op       = w_cell_op;
        assign w_ctrl.occupied = TCW'(gi) < r_tcount;
        assign w_ctrl.at_tail  = TCW'(gi) == r_tcount;

        if (gi == 0) begin : g_first
            assign w_left_dl      = '0;
            assign w_left_task    = '0;
            assign w_left_greater = 1'b0;
        end else begin : g_inner
            assign w_left_dl      = w_dl[gi-1];
            assign w_left_task    = w_task[gi-1];
            assign w_left_greater = w_greater[gi-1];
        end

        if (gi == TIMER_DEPTH - 1) begin : g_last
            assign w_right_dl   = w_dl[gi];
            assign w_right_task = w_task[gi];
        end else begin : g_mid
            assign w_right_dl   = w_dl[gi+1];
            assign w_right_task = w_task[gi+1];
        end

        rtts_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_new_dl      (r_deadline),
            .i_new_task    (r_req.task_first),
            .i_left_dl     (w_left_dl),
            .i_left_task   (w_left_task),
            .i_left_greater(w_left_greater),
            .i_right_dl    (w_right_dl),
            .i_right_task  (w_right_task),
            .o_dl          (w_dl[gi]),
            .o_task        (w_task[gi]),
            .o_greater     (w_greater[gi])
        );
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    a_ready_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcount <= RCW'(READY_DEPTH))
        else $error("ready count exceeds depth");

    a_timer_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcount <= TCW'(TIMER_DEPTH))
        else $error("timer count exceeds depth");

    a_timed_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_req.cmd == CMD_PUSH_TIMED && !w_timer_full)
        |=> (r_tcount == $past(r_tcount) + 1'b1))
        else $error("timed request did not grow the timer queue");

    for (genvar gs = 0; gs + 1 < TIMER_DEPTH; gs++) begin : g_sorted
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_tcount > TCW'(gs + 1)) |-> (w_dl[gs] <= w_dl[gs+1]))
            else $error("timer chain out of deadline order");
    end

endmodule

`default_nettype wire

[tb/tb_ready_and_timer_task_scheduler_top.sv]
// Self-checking testbench for ready_and_timer_task_scheduler_top: a directed table,
// then random command mixes under several idle and stall patterns, scored against
// an in-bench scheduler predictor. Depends on rtts_pkg and the top level only.
`timescale 1ns / 1ps

module tb_ready_and_timer_task_scheduler_top;
    import rtts_pkg::*;

    localparam int READY_DEPTH = 16;
    localparam int TIMER_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 240;
    localparam int N_DIRECTED  = 26;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_result  res;
    } t_dir_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_request i_req;
    logic     o_valid;
    logic     i_ready;
    t_result  o_res;

    logic [TASK_BITS-1:0] ready_ids [READY_DEPTH];
    int                   ready_rd_ptr;
    int                   ready_len;
    logic [47:0]          timer_deadline [TIMER_DEPTH];
    logic [TASK_BITS-1:0] timer_id [TIMER_DEPTH];
    int                   timer_len;
    logic [47:0]          sched_time;

    t_result     scheduled_results [$];
    int          errors;
    int          cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    t_dir_row directed [N_DIRECTED] = '{
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b1,
          '{ST_NO_TASK, 16'h0000, 48'd0}},
        '{'{CMD_PUSH_ONE,   16'hFFFF, 16'h0000, 32'd0, 48'd0}, 1'b1,
          '{ST_ACCEPTED, 16'h0000, 48'd0}},
        '{'{CMD_DISPATCH,   16'h0000, 16'hFFFF, 32'd0, 48'd0}, 1'b1,
          '{ST_DISPATCHED, 16'hFFFF, 48'd0}},
        '{'{CMD_PUSH_TWO,   16'h0000, 16'h1234, 32'd0, 48'd0}, 1'b1,
          '{ST_ACCEPTED, 16'h0000, 48'd0}},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b1,
          '{ST_DISPATCHED, 16'h0000, 48'd0}},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b1,
          '{ST_DISPATCHED, 16'h1234, 48'd0}},
        '{'{CMD_PUSH_TIMED, 16'h0007, 16'h0000, 32'd100, 48'd1000}, 1'b1,
          '{ST_ACCEPTED, 16'h0000, 48'd0}},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b1,
          '{ST_DISPATCHED, 16'h0007, 48'd100}},
        '{'{CMD_PUSH_TIMED, 16'h00AA, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF}, 1'b1,
          '{ST_ACCEPTED, 16'h0000, 48'd0}},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF}, 1'b1,
          '{ST_DISPATCHED, 16'h00AA, 48'd0}},
        '{'{CMD_PUSH_TIMED, 16'h0011, 16'h0000, 32'd5, 48'd0}, 1'b1,
          '{ST_ACCEPTED, 16'h0000, 48'd0}},
        '{'{CMD_PUSH_TIMED, 16'h0022, 16'h0000, 32'd5, 48'd0}, 1'b1,
          '{ST_ACCEPTED, 16'h0000, 48'd0}},
        '{'{CMD_PUSH_TIMED, 16'h0033, 16'h0000, 32'd2, 48'd3}, 1'b1,
          '{ST_ACCEPTED, 16'h0000, 48'd0}},
        '{'{CMD_PUSH_ONE,   16'h0044, 16'h0000, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_PUSH_ONE,   16'h0055, 16'h0000, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b1,
          '{ST_NO_TASK, 16'h0000, 48'd0}},
        '{'{CMD_PUSH_TIMED, 16'h0066, 16'h0000, 32'd0, 48'h8000_0000_0000}, 1'b0, '0},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_PUSH_TWO,   16'hFFFF, 16'hFFFF, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b0, '0},
        '{'{CMD_DISPATCH,   16'h0000, 16'h0000, 32'd0, 48'd0}, 1'b0, '0}
    };

    ready_and_timer_task_scheduler_top #(
        .READY_DEPTH(READY_DEPTH),
        .TIMER_DEPTH(TIMER_DEPTH),
        .TIME_BITS  (48)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_res  (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void ready_append(input logic [TASK_BITS-1:0] id);
        ready_ids[(ready_rd_ptr + ready_len) % READY_DEPTH] = id;
        ready_len++;
    endfunction

    function automatic t_result schedule_step(input t_request r);
        t_result              res;
        logic [48:0]          sum;
        logic [47:0]          dl;
        logic [TASK_BITS-1:0] id;
        logic                 move;
        int                   pos;
        res = '{status: ST_ACCEPTED, task_out: '0, waited_ticks: '0};
        case (r.cmd)
            CMD_PUSH_ONE: begin
                if (ready_len >= READY_DEPTH) begin
                    res.status = ST_READY_FULL;
                end else begin
                    ready_append(r.task_first);
                end
            end
            CMD_PUSH_TWO: begin
                if (ready_len + 2 > READY_DEPTH) begin
                    res.status = ST_READY_FULL;
                end else begin
                    ready_append(r.task_first);
                    ready_append(r.task_second);
                end
            end
            CMD_PUSH_TIMED: begin
                if (timer_len >= TIMER_DEPTH) begin
                    res.status = ST_TIMER_FULL;
                end else begin
                    sched_time = r.time_now;
                    sum = {1'b0, r.time_now} + {17'd0, r.delay_ticks};
                    dl = sum[48] ? '1 : sum[47:0];
                    pos = timer_len;
                    while (pos > 0 && timer_deadline[pos-1] > dl) begin
                        timer_deadline[pos] = timer_deadline[pos-1];
                        timer_id[pos] = timer_id[pos-1];
                        pos--;
                    end
                    timer_deadline[pos] = dl;
                    timer_id[pos] = r.task_first;
                    timer_len++;
                end
            end
            default: begin
                if (timer_len > 0) begin
                    dl = timer_deadline[0];
                    if (ready_len == 0) begin
                        if (sched_time < dl) begin
                            res.waited_ticks = dl - sched_time;
                            sched_time = dl;
                        end
                        move = 1'b1;
                    end else begin
                        move = (sched_time >= dl) && (ready_len < READY_DEPTH);
                    end
                    if (move) begin
                        id = timer_id[0];
                        for (pos = 1; pos < timer_len; pos++) begin
                            timer_deadline[pos-1] = timer_deadline[pos];
                            timer_id[pos-1] = timer_id[pos];
                        end
                        timer_len--;
                        ready_append(id);
                    end
                end
                if (ready_len > 0) begin
                    res.task_out = ready_ids[ready_rd_ptr];
                    ready_rd_ptr = (ready_rd_ptr + 1) % READY_DEPTH;
                    ready_len--;
                    res.status = ST_DISPATCHED;
                end else begin
                    res.status = ST_NO_TASK;
                    res.waited_ticks = '0;
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_request random_request(input bit filling);
        t_request    r;
        int unsigned pick;
        logic [63:0] wide;
        pick = $urandom_range(99);
        if (filling) begin
            if (pick < 25)      r.cmd = CMD_PUSH_ONE;
            else if (pick < 45) r.cmd = CMD_PUSH_TWO;
            else if (pick < 85) r.cmd = CMD_PUSH_TIMED;
            else                r.cmd = CMD_DISPATCH;
        end else begin
            if (pick < 10)      r.cmd = CMD_PUSH_ONE;
            else if (pick < 20) r.cmd = CMD_PUSH_TWO;
            else if (pick < 30) r.cmd = CMD_PUSH_TIMED;
            else                r.cmd = CMD_DISPATCH;
        end
        wide = {$urandom, $urandom};
        r.task_first = wide[15:0];
        r.task_second = wide[31:16];
        pick = $urandom_range(99);
        if (pick < 50)      r.delay_ticks = $urandom_range(100);
        else if (pick < 75) r.delay_ticks = $urandom_range(5000);
        else if (pick < 90) r.delay_ticks = $urandom;
        else if (pick < 95) r.delay_ticks = '0;
        else                r.delay_ticks = '1;
        wide = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 60)      r.time_now = sched_time + 48'($urandom_range(200));
        else if (pick < 75) r.time_now = sched_time - 48'($urandom_range(200));
        else if (pick < 90) r.time_now = wide[47:0];
        else if (pick < 95) r.time_now = '1;
        else                r.time_now = '0;
        return r;
    endfunction

    task automatic send_request(input t_request r, input logic typed, input t_result exp);
        t_result pred;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_ready);
        pred = schedule_step(r);
        scheduled_results.push_back(typed ? exp : pred);
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result exp;
        if (i_rst_n && o_valid && i_ready) begin
            if (scheduled_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d task=%h waited=%h",
                         $time, o_res.status, o_res.task_out, o_res.waited_ticks);
                errors++;
            end else begin
                exp = scheduled_results.pop_front();
                if (o_res.status !== exp.status || o_res.task_out !== exp.task_out
                        || o_res.waited_ticks !== exp.waited_ticks) begin
                    $display("%0t: expected status=%0d task=%h waited=%h, got %0d %h %h",
                             $time, exp.status, exp.task_out, exp.waited_ticks,
                             o_res.status, o_res.task_out, o_res.waited_ticks);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL ready_and_timer_task_scheduler_top");
            $finish;
        end
    end

    initial begin
        int unsigned idle_mix [4][2];
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ready_rd_ptr = 0;
        ready_len = 0;
        timer_len = 0;
        sched_time = '0;
        idle_mix = '{'{0, 0}, '{56, 0}, '{0, 56}, '{17, 17}};
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ready <= 1'b0;
        i_req <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(directed[i].req, directed[i].typed, directed[i].res);
        end

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_mix[p][0];
            recv_stall_pct = idle_mix[p][1];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_request(random_request((i % 120) < 70), 1'b0, '0);
            end
        end
        i_valid <= 1'b0;
        recv_stall_pct = 0;

        while (scheduled_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS ready_and_timer_task_scheduler_top");
        end else begin
            $display("FAIL ready_and_timer_task_scheduler_top");
        end
        $finish;
    end

endmodule
